// ===== hw/rtl/arled_pkg.sv =====
// ----------------------------------------------------------------------------
// arled_pkg
// Shared types, constants and elaboration-time table helpers for the
// auto-ranging sample to LED color core.
// ----------------------------------------------------------------------------
package arled_pkg;

   localparam int unsigned SAMPLE_W      = 12;
   localparam int unsigned OP_W          = 2;
   localparam int unsigned COLOR_W       = 24;
   localparam int unsigned CHAN_W        = 8;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned CSR_DATA_W    = 12;
   localparam int unsigned FRAC_MAX_W    = 12;
   localparam int unsigned SCALE_STEPS   = CHAN_W;

   localparam int unsigned BRIGHTNESS_BASE_DEF = 16;
   localparam int unsigned FRACTION_BITS_DEF   = 8;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_RED     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_GREEN   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_BLUE    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [SAMPLE_W-1:0] numer;
      logic [SAMPLE_W:0]   denom;
   } div_cmd_type;

   // Q32 product, truncated
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   function automatic logic power_too_big(input logic [63:0] r, input logic [63:0] limit,
                                          input int unsigned fb);
      logic [63:0] v;
      logic        big;
      v   = r;
      big = 1'b0;
      for (int unsigned i = 0; i < fb; i++) begin
         if (!big) begin
            v = qmul(v, v);
            if (v > limit) big = 1'b1;
         end
      end
      return big || (v > limit);
   endfunction

   function automatic logic [63:0] find_root(input int unsigned b, input int unsigned fb);
      logic [63:0] limit;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      limit = 64'(b) << 32;
      lo    = 64'd1 << 32;
      hi    = 64'd2 << 32;
      for (int i = 0; i < 32; i++) begin
         mid = lo + ((hi - lo) >> 1);
         if (power_too_big(mid, limit, fb)) hi = mid;
         else lo = mid;
      end
      return lo;
   endfunction

   // (root^f - 1) * 256 / (b - 1), limited to 255; quotient found bit by bit
   function automatic logic [CHAN_W-1:0] intensity_of(input logic [FRAC_MAX_W-1:0] f,
                                                      input logic [63:0] root,
                                                      input int unsigned b,
                                                      input int unsigned fb);
      logic [63:0]       y;
      logic [63:0]       pw;
      logic [63:0]       num;
      logic [63:0]       den;
      logic [CHAN_W-1:0] q;
      logic [CHAN_W-1:0] cand;
      y  = 64'd1 << 32;
      pw = root;
      for (int unsigned i = 0; i < fb; i++) begin
         if (f[i]) y = qmul(y, pw);
         pw = qmul(pw, pw);
      end
      num = (y - (64'd1 << 32)) << 8;
      den = 64'(b - 1) << 32;
      q   = '0;
      for (int k = CHAN_W - 1; k >= 0; k--) begin
         cand = q | (CHAN_W'(1) << k);
         if (64'(cand) * den <= num) q = cand;
      end
      return q;
   endfunction

   // floor(x / 255) for x below 65280, which covers any 8-bit by 8-bit product
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
      logic [2*CHAN_W:0] t;
      t = {1'b0, x} + {9'd0, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

// ===== hw/rtl/arled_req_if.sv =====
// ----------------------------------------------------------------------------
// arled_req_if
// Request channel: operation code and converter sample.
// ----------------------------------------------------------------------------
interface arled_req_if;
   logic                          valid;
   logic                          ready;
   logic [arled_pkg::OP_W-1:0]     op;
   logic [arled_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

// ===== hw/rtl/arled_rsp_if.sv =====
// ----------------------------------------------------------------------------
// arled_rsp_if
// Response channel: LED enable and packed color.
// ----------------------------------------------------------------------------
interface arled_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         led_on;
   logic [arled_pkg::COLOR_W-1:0] color;

   modport source (output valid, output led_on, output color, input ready);
   modport sink   (input valid, input led_on, input color, output ready);
endinterface

// ===== hw/rtl/arled_div.sv =====
// ----------------------------------------------------------------------------
// arled_div
// Bit-serial restoring divider: fraction = (numer << FractionBits) / denom,
// one quotient bit per cycle. Requires numer < denom.
// ----------------------------------------------------------------------------
module arled_div #(
   parameter int unsigned FractionBits = arled_pkg::FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  arled_pkg::div_cmd_type  cmd,
   output logic                    done,
   output logic [FractionBits-1:0] quot
);

   localparam int unsigned CntW = $clog2(FractionBits + 1);

   logic [arled_pkg::SAMPLE_W-1:0] rem_ff,  rem_in;
   logic [arled_pkg::SAMPLE_W:0]   den_ff,  den_in;
   logic [FractionBits-1:0]        quot_ff, quot_in;
   logic [CntW-1:0]                cnt_ff,  cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [arled_pkg::SAMPLE_W:0]   shifted;
   logic                           ge;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      ge      = (shifted >= den_ff);
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in  = cmd.numer;
         den_in  = cmd.denom;
         cnt_in  = CntW'(FractionBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) rem_in = arled_pkg::SAMPLE_W'(shifted - den_ff);
         else    rem_in = shifted[arled_pkg::SAMPLE_W-1:0];
         quot_in = {quot_ff[FractionBits-2:0], ge};
         cnt_in  = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hw/rtl/autorange_sample_to_led_color_core.sv =====
// ----------------------------------------------------------------------------
// autorange_sample_to_led_color_core
// Tracks a sample window, maps the sample position in it to an exponential
// brightness and scales the configured base color.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid / ready    | op[1:0], sample[11:0]
//   rsp     | out | valid / ready    | led_on, color[23:0]
//   csr     | in  | csr_we           | csr_index[1:0], csr_wdata[11:0]
//
// Update while armed: from transfer to next ready the core runs the bit-serial
// divider (one bit per cycle), the table lookup, the 8-step shift-add color
// scaler and the emit step. Start and ignored ops keep it idle; Stop goes to emit.
// Reset is synchronous; the result register lets a new request transfer
// while the previous response is stalled; the emit step waits for it.
// ----------------------------------------------------------------------------
module autorange_sample_to_led_color_core #(
   parameter int unsigned BrightnessBase = arled_pkg::BRIGHTNESS_BASE_DEF,
   parameter int unsigned FractionBits   = arled_pkg::FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   arled_req_if.sink                          req,
   arled_rsp_if.source                        rsp,
   input  logic                               csr_we,
   input  logic [arled_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [arled_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned W          = arled_pkg::SAMPLE_W;
   localparam int unsigned CW         = arled_pkg::CHAN_W;
   localparam int unsigned TableDepth = 1 << FractionBits;
   localparam int unsigned MaxSteps   = (FractionBits > arled_pkg::SCALE_STEPS) ?
                                        FractionBits : arled_pkg::SCALE_STEPS;
   localparam int unsigned CntW       = $clog2(MaxSteps + 1);
   localparam logic [63:0] Root       = arled_pkg::find_root(BrightnessBase, FractionBits);

   arled_pkg::state_type state_ff, state_in;

   logic [W-1:0]      width_ff;
   logic [CW-1:0]     red_ff, green_ff, blue_ff;
   logic [W-1:0]      low_ff,  low_in;
   logic [W-1:0]      high_ff, high_in;
   logic              armed_ff, armed_in;
   logic              pend_on_ff, pend_on_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]     mbits_ff, mbits_in;
   logic [2*CW-1:0]   acc_r_ff, acc_r_in;
   logic [2*CW-1:0]   acc_g_ff, acc_g_in;
   logic [2*CW-1:0]   acc_b_ff, acc_b_in;
   logic [CW-1:0]     rom_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_on_ff, rsp_on_in;
   logic [arled_pkg::COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic [CW-1:0]           inten_rom [TableDepth];
   arled_pkg::div_cmd_type  div_cmd;
   logic                    div_done;
   logic [FractionBits-1:0] div_quot;

   logic           xfer;
   logic           out_free;
   logic [W-1:0]   half;
   logic [W:0]     seed_sum;
   logic [W-1:0]   seed_high;
   logic [W-1:0]   seed_low;
   logic [W-1:0]   upd_low;
   logic [W-1:0]   upd_high;

   for (genvar i = 0; i < TableDepth; i++) begin : g_rom
      assign inten_rom[i] = arled_pkg::intensity_of(arled_pkg::FRAC_MAX_W'(i), Root,
                                                     BrightnessBase, FractionBits);
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= inten_rom[div_quot];
   end

   arled_div #(
      .FractionBits(FractionBits)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .cmd  (div_cmd),
      .done (div_done),
      .quot (div_quot)
   );

   assign req.ready  = (state_ff == arled_pkg::ST_IDLE);
   assign xfer       = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      half      = {1'b0, width_ff[W-1:1]};
      seed_sum  = {1'b0, req.sample} + {1'b0, half};
      seed_high = seed_sum[W] ? arled_pkg::SAMPLE_MAX : seed_sum[W-1:0];
      seed_low  = (req.sample > half) ? (req.sample - half) : '0;
      upd_low   = (req.sample < low_ff)  ? req.sample : low_ff;
      upd_high  = (req.sample > high_ff) ? req.sample : high_ff;
   end

   always_comb begin
      state_in      = state_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      armed_in      = armed_ff;
      pend_on_in    = pend_on_ff;
      cnt_in        = cnt_ff;
      mbits_in      = mbits_ff;
      acc_r_in      = acc_r_ff;
      acc_g_in      = acc_g_ff;
      acc_b_in      = acc_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_on_in     = rsp_on_ff;
      rsp_color_in  = rsp_color_ff;
      div_cmd.start = 1'b0;
      div_cmd.numer = req.sample - upd_low;
      div_cmd.denom = {1'b0, upd_high} - {1'b0, upd_low} + (W+1)'(1);

      unique case (state_ff)
         arled_pkg::ST_IDLE: begin
            if (xfer) begin
               unique case (req.op)
                  arled_pkg::OP_START: begin
                     low_in   = seed_low;
                     high_in  = seed_high;
                     armed_in = 1'b1;
                  end
                  arled_pkg::OP_STOP: begin
                     low_in     = seed_low;
                     high_in    = seed_high;
                     armed_in   = 1'b0;
                     pend_on_in = 1'b0;
                     state_in   = arled_pkg::ST_EMIT;
                  end
                  arled_pkg::OP_UPDATE: begin
                     if (armed_ff) begin
                        low_in        = upd_low;
                        high_in       = upd_high;
                        pend_on_in    = 1'b1;
                        div_cmd.start = 1'b1;
                        state_in      = arled_pkg::ST_DIVIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         arled_pkg::ST_DIVIDE: begin
            if (div_done) state_in = arled_pkg::ST_LOOKUP;
         end
         arled_pkg::ST_LOOKUP: begin
            mbits_in = rom_q_ff;
            acc_r_in = '0;
            acc_g_in = '0;
            acc_b_in = '0;
            cnt_in   = CntW'(arled_pkg::SCALE_STEPS);
            state_in = arled_pkg::ST_SCALE;
         end
         arled_pkg::ST_SCALE: begin
            acc_r_in = {acc_r_ff[2*CW-2:0], 1'b0} + (mbits_ff[CW-1] ? {8'd0, red_ff}   : '0);
            acc_g_in = {acc_g_ff[2*CW-2:0], 1'b0} + (mbits_ff[CW-1] ? {8'd0, green_ff} : '0);
            acc_b_in = {acc_b_ff[2*CW-2:0], 1'b0} + (mbits_ff[CW-1] ? {8'd0, blue_ff}  : '0);
            mbits_in = {mbits_ff[CW-2:0], 1'b0};
            cnt_in   = cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) state_in = arled_pkg::ST_EMIT;
         end
         arled_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_on_in    = pend_on_ff;
               rsp_color_in = pend_on_ff ? {arled_pkg::div255(acc_r_ff),
                                            arled_pkg::div255(acc_g_ff),
                                            arled_pkg::div255(acc_b_ff)} : '0;
               state_in     = arled_pkg::ST_IDLE;
            end
         end
         default: state_in = arled_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arled_pkg::ST_IDLE;
         width_ff     <= 12'd256;
         red_ff       <= 8'd255;
         green_ff     <= 8'd255;
         blue_ff      <= 8'd255;
         low_ff       <= '0;
         high_ff      <= arled_pkg::SAMPLE_MAX;
         armed_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         armed_ff     <= armed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               arled_pkg::CSR_WINDOW_WIDTH: width_ff <= csr_wdata;
               arled_pkg::CSR_BASE_RED:     red_ff   <= csr_wdata[CW-1:0];
               arled_pkg::CSR_BASE_GREEN:   green_ff <= csr_wdata[CW-1:0];
               arled_pkg::CSR_BASE_BLUE:    blue_ff  <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end
      end
      pend_on_ff   <= pend_on_in;
      mbits_ff     <= mbits_in;
      acc_r_ff     <= acc_r_in;
      acc_g_ff     <= acc_g_in;
      acc_b_ff     <= acc_b_in;
      rsp_on_ff    <= rsp_on_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.led_on = rsp_on_ff;
   assign rsp.color  = rsp_color_ff;

endmodule

// ===== dv/tb_autorange_sample_to_led_color_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autorange_sample_to_led_color_core
// Self-checking bench for the auto-ranging LED color core. Requests go in with
// random gaps and responses are taken under random backpressure. A behavioral
// model of the sample window, the exponential brightness curve and the color
// scaling predicts every response, and each field is compared in order.
// ----------------------------------------------------------------------------
module tb_autorange_sample_to_led_color_core;

   localparam int unsigned BRIGHT_BASE   = arled_pkg::BRIGHTNESS_BASE_DEF;
   localparam int unsigned FRAC_BITS     = arled_pkg::FRACTION_BITS_DEF;
   localparam int unsigned LEVELS        = 1 << FRAC_BITS;
   localparam int unsigned SETTLE_CYCLES = 2 * (FRAC_BITS + 12);
   localparam int unsigned RANDOM_ITEMS  = 1470;
   localparam int unsigned PHASES        = 12;
   localparam logic [arled_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                          led_on;
      logic [arled_pkg::COLOR_W-1:0] color;
   } led_word_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [arled_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [arled_pkg::CSR_DATA_W-1:0]  csr_wdata;

   arled_req_if req_if ();
   arled_rsp_if rsp_if ();

   autorange_sample_to_led_color_core #(
      .BrightnessBase (BRIGHT_BASE),
      .FractionBits   (FRAC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [arled_pkg::SAMPLE_W-1:0] width_cfg;
   logic [arled_pkg::CHAN_W-1:0]   red_cfg;
   logic [arled_pkg::CHAN_W-1:0]   green_cfg;
   logic [arled_pkg::CHAN_W-1:0]   blue_cfg;
   logic [arled_pkg::SAMPLE_W-1:0] win_low;
   logic [arled_pkg::SAMPLE_W-1:0] win_high;
   logic                           armed_mdl;
   logic [arled_pkg::CHAN_W-1:0]   brightness_lut [LEVELS];

   led_word_type expected_colors [$];

   int errors     = 0;
   int n_lit      = 0;
   int n_off      = 0;
   int n_starts;
   int n_ignored;
   int gap_max;
   int stall_max;
   int stall_left = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[95:32];
   endfunction

   // largest Q32 root in [1,2] whose 2^FRAC_BITS power stays within the base
   function automatic logic [63:0] brightness_root();
      logic [63:0] limit;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] v;
      logic        over;
      limit = 64'(BRIGHT_BASE) << 32;
      lo    = 64'd1 << 32;
      hi    = 64'd2 << 32;
      while (hi - lo > 64'd1) begin
         mid  = lo + ((hi - lo) >> 1);
         v    = mid;
         over = 1'b0;
         for (int i = 0; i < FRAC_BITS && !over; i++) begin
            v    = q32_mul(v, v);
            over = (v > limit);
         end
         if (over) hi = mid;
         else lo = mid;
      end
      return lo;
   endfunction

   function automatic void build_brightness_lut();
      logic [63:0] root;
      logic [63:0] y;
      logic [63:0] pw;
      logic [63:0] q;
      int unsigned e;
      root = brightness_root();
      for (int f = 0; f < LEVELS; f++) begin
         y  = 64'd1 << 32;
         pw = root;
         e  = 32'(f);
         while (e != 0) begin
            if (e[0]) y = q32_mul(y, pw);
            e = e >> 1;
            if (e != 0) pw = q32_mul(pw, pw);
         end
         q = ((y - (64'd1 << 32)) * 64'd256) / (64'(BRIGHT_BASE - 1) << 32);
         brightness_lut[FRAC_BITS'(f)] = (q > 64'd255) ? 8'd255 : q[7:0];
      end
   endfunction

   function automatic void seed_window(input logic [arled_pkg::SAMPLE_W-1:0] s);
      int unsigned half;
      int unsigned top;
      half     = 32'(width_cfg >> 1);
      top      = 32'(s) + half;
      win_high = (top > 32'(arled_pkg::SAMPLE_MAX)) ? arled_pkg::SAMPLE_MAX :
                 arled_pkg::SAMPLE_W'(top);
      win_low  = (32'(s) > half) ? arled_pkg::SAMPLE_W'(32'(s) - half) : '0;
   endfunction

   function automatic logic [arled_pkg::CHAN_W-1:0] scale_channel(
         input logic [arled_pkg::CHAN_W-1:0] base,
         input logic [arled_pkg::CHAN_W-1:0] level);
      int unsigned p;
      p = 32'(base) * 32'(level);
      return arled_pkg::CHAN_W'(p / 255);
   endfunction

   // returns 1 when the request produces a response
   function automatic bit predict_led(input logic [arled_pkg::OP_W-1:0] op,
                                      input logic [arled_pkg::SAMPLE_W-1:0] s,
                                      output led_word_type res);
      int unsigned frac;
      logic [arled_pkg::CHAN_W-1:0] level;
      res = '0;
      if (op == arled_pkg::OP_START) begin
         seed_window(s);
         armed_mdl = 1'b1;
         return 1'b0;
      end
      if (op == arled_pkg::OP_STOP) begin
         seed_window(s);
         armed_mdl = 1'b0;
         return 1'b1;
      end
      if (op != arled_pkg::OP_UPDATE || !armed_mdl) return 1'b0;
      if (s > win_high) win_high = s;
      if (s < win_low) win_low = s;
      frac  = ((32'(s) - 32'(win_low)) << FRAC_BITS) / (32'(win_high) - 32'(win_low) + 1);
      level = brightness_lut[FRAC_BITS'(frac)];
      res.led_on = 1'b1;
      res.color  = {scale_channel(red_cfg, level), scale_channel(green_cfg, level),
                    scale_channel(blue_cfg, level)};
      return 1'b1;
   endfunction

   // ------------------------------------------------------------- response side

   always @(posedge clock) begin : rsp_monitor
      led_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_colors.size() == 0) begin
            $error("unexpected response: led_on %0d color %06h", rsp_if.led_on, rsp_if.color);
            errors++;
         end else begin
            want = expected_colors.pop_front();
            if (rsp_if.led_on !== want.led_on) begin
               $error("led_on mismatch: expected %0d, actual %0d", want.led_on, rsp_if.led_on);
               errors++;
            end
            if (rsp_if.color !== want.color) begin
               $error("color mismatch: expected %06h, actual %06h", want.color, rsp_if.color);
               errors++;
            end
            if (want.led_on) n_lit++;
            else n_off++;
         end
         stall_left = int'($urandom_range(0, stall_max));
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_if.ready <= (stall_left == 0);
   end

   // -------------------------------------------------------------- request side

   task automatic send_request(input logic [arled_pkg::OP_W-1:0] op,
                               input logic [arled_pkg::SAMPLE_W-1:0] s);
      int           gap;
      led_word_type res;
      gap = int'($urandom_range(0, gap_max));
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.op     <= op;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      if (predict_led(op, s, res)) expected_colors.push_back(res);
      else if (op == arled_pkg::OP_START) n_starts++;
      else n_ignored++;
   endtask

   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [arled_pkg::SAMPLE_W-1:0] w,
                              input logic [arled_pkg::CHAN_W-1:0] r,
                              input logic [arled_pkg::CHAN_W-1:0] g,
                              input logic [arled_pkg::CHAN_W-1:0] b);
      csr_we    <= 1'b1;
      csr_index <= arled_pkg::CSR_WINDOW_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= arled_pkg::CSR_BASE_RED;
      csr_wdata <= arled_pkg::CSR_DATA_W'(r);
      @(posedge clock);
      csr_index <= arled_pkg::CSR_BASE_GREEN;
      csr_wdata <= arled_pkg::CSR_DATA_W'(g);
      @(posedge clock);
      csr_index <= arled_pkg::CSR_BASE_BLUE;
      csr_wdata <= arled_pkg::CSR_DATA_W'(b);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      width_cfg = w;
      red_cfg   = r;
      green_cfg = g;
      blue_cfg  = b;
   endtask

   function automatic logic [arled_pkg::SAMPLE_W-1:0] random_sample();
      int pick;
      pick = int'($urandom_range(0, 9));
      if (pick == 0) return '0;
      if (pick == 1) return arled_pkg::SAMPLE_MAX;
      return arled_pkg::SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   // half the time close to the seed so the window stays narrow for a while
   function automatic logic [arled_pkg::SAMPLE_W-1:0] near_sample(
         input logic [arled_pkg::SAMPLE_W-1:0] seed);
      int pick;
      int span;
      int v;
      pick = int'($urandom_range(0, 9));
      if (pick < 5) begin
         span = int'($urandom_range(1, 128));
         v    = int'(seed) + int'($urandom_range(0, 2 * span)) - span;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         return arled_pkg::SAMPLE_W'(v);
      end
      if (pick == 5) return win_low;
      if (pick == 6) return win_high;
      return random_sample();
   endfunction

   function automatic logic [arled_pkg::SAMPLE_W-1:0] random_width();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return arled_pkg::SAMPLE_MAX;
         2: return arled_pkg::SAMPLE_W'(1);
         3: return arled_pkg::SAMPLE_W'($urandom_range(0, 64));
         default: return arled_pkg::SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [arled_pkg::CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 8'hFF;
         default: return arled_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // ------------------------------------------------------------------- tests

   task automatic test_power_on_defaults();
      gap_max   = 0;
      stall_max = 0;
      send_request(arled_pkg::OP_UPDATE, 12'd2048);
      send_request(OP_UNUSED, arled_pkg::SAMPLE_MAX);
      send_request(arled_pkg::OP_STOP, 12'd0);
      send_request(arled_pkg::OP_START, 12'd2048);
      send_request(arled_pkg::OP_UPDATE, 12'd2048);
      send_request(arled_pkg::OP_UPDATE, 12'd1920);
      send_request(arled_pkg::OP_UPDATE, 12'd2176);
      send_request(OP_UNUSED, 12'd100);
      send_request(arled_pkg::OP_UPDATE, 12'd0);
      send_request(arled_pkg::OP_UPDATE, arled_pkg::SAMPLE_MAX);
      send_request(arled_pkg::OP_UPDATE, 12'd1000);
      send_request(arled_pkg::OP_STOP, arled_pkg::SAMPLE_MAX);
      send_request(arled_pkg::OP_UPDATE, 12'd5);
      send_request(arled_pkg::OP_START, 12'd0);
      send_request(arled_pkg::OP_UPDATE, 12'd0);
      send_request(arled_pkg::OP_START, arled_pkg::SAMPLE_MAX);
      send_request(arled_pkg::OP_UPDATE, arled_pkg::SAMPLE_MAX);
      drain_pipeline();
   endtask

   task automatic test_window_limits();
      gap_max   = 8;
      stall_max = 8;
      load_config('0, 8'hFF, 8'h00, 8'h00);
      send_request(arled_pkg::OP_START, 12'd100);
      send_request(arled_pkg::OP_UPDATE, 12'd100);
      send_request(arled_pkg::OP_UPDATE, 12'd101);
      drain_pipeline();
      load_config(arled_pkg::SAMPLE_MAX, 8'h00, 8'hFF, 8'h80);
      send_request(arled_pkg::OP_START, 12'd2048);
      send_request(arled_pkg::OP_UPDATE, arled_pkg::SAMPLE_MAX);
      send_request(arled_pkg::OP_UPDATE, 12'd1);
      drain_pipeline();
      load_config(12'd1, 8'h00, 8'h00, 8'h00);
      send_request(arled_pkg::OP_START, 12'd3000);
      send_request(arled_pkg::OP_UPDATE, 12'd3001);
      drain_pipeline();
   endtask

   task automatic test_random_traffic();
      int                             counted;
      int                             pick;
      logic [arled_pkg::SAMPLE_W-1:0] seed;
      seed = 12'd2048;
      for (int p = 0; p < PHASES; p++) begin
         drain_pipeline();
         gap_max   = (p % 3 == 0) ? 0 : 8;
         stall_max = (p % 4 == 1) ? 0 : 8;
         load_config(random_width(), random_channel(), random_channel(), random_channel());
         counted = 0;
         while (counted < RANDOM_ITEMS / PHASES) begin
            pick = int'($urandom_range(0, 99));
            if (!armed_mdl) begin
               if (pick < 80) begin
                  seed = random_sample();
                  send_request(arled_pkg::OP_START, seed);
                  counted++;
               end else if (pick < 88) begin
                  send_request(arled_pkg::OP_STOP, random_sample());
                  counted++;
               end else if (pick < 94) begin
                  send_request(arled_pkg::OP_UPDATE, random_sample());
               end else begin
                  send_request(OP_UNUSED, random_sample());
               end
            end else begin
               if (pick < 85) begin
                  send_request(arled_pkg::OP_UPDATE, near_sample(seed));
                  counted++;
               end else if (pick < 91) begin
                  seed = random_sample();
                  send_request(arled_pkg::OP_START, seed);
                  counted++;
               end else if (pick < 97) begin
                  send_request(arled_pkg::OP_STOP, random_sample());
                  counted++;
               end else begin
                  send_request(OP_UNUSED, random_sample());
               end
            end
         end
      end
   endtask

   // -------------------------------------------------------------------- main

   initial begin
      n_starts      = 0;
      n_ignored     = 0;
      gap_max       = 0;
      stall_max     = 0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = arled_pkg::CSR_WINDOW_WIDTH;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.op     = arled_pkg::OP_START;
      req_if.sample = '0;
      width_cfg     = 12'd256;
      red_cfg       = 8'hFF;
      green_cfg     = 8'hFF;
      blue_cfg      = 8'hFF;
      win_low       = '0;
      win_high      = arled_pkg::SAMPLE_MAX;
      armed_mdl     = 1'b0;
      build_brightness_lut();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_power_on_defaults();
      test_window_limits();
      test_random_traffic();
      drain_pipeline();
      $display("checked %0d lit and %0d off responses", n_lit, n_off);
      $display("over %0d window seeds and %0d ignored requests, %0d mismatches",
               n_starts, n_ignored, errors);
      if (errors == 0) begin
         $display("autorange_sample_to_led_color_core regression: pass");
      end else begin
         $display("autorange_sample_to_led_color_core regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for responses");
      $display("autorange_sample_to_led_color_core regression: fail");
      $finish;
   end

endmodule
